>>> hdl/playfair_digraph_cipher_assert.svh
// Assertion macros shared by the cipher RTL.
// Both forms sample on the rising clock edge and are disabled while reset is low.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`ifndef ASSERT_OFF
// A property that must hold at every sampled edge.
`define PDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by a consequence at the next edge.
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/pdc_pkg.sv
`default_nettype none

package pdc_pkg;

  // Geometry of the key square.
  localparam int SIDE   = 5;
  localparam int CODE_W = 5;
  localparam int IDX_W  = $clog2(SIDE);
  localparam int ROW_W  = SIDE * CODE_W;

  // Filler letter 'x'.
  localparam logic [CODE_W-1:0] FILLER_X = 5'd23;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW3  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ROW4  = 3'd5;

  // Key square: row index outermost, column 0 in the lowest bits of a row.
  typedef logic [SIDE-1:0][SIDE-1:0][CODE_W-1:0] square_t;

  // Reset square: a b c d e / f g h i j / k l m n o / p r s t u / v w x y z.
  localparam square_t SQUARE_RESET = {25'd27025109, 25'd21613103, 25'd15118698,
                                      25'd9706693, 25'd4294688};

  // Input and result transactions.
  typedef struct packed {
    logic [CODE_W-1:0] letter;
    logic              end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_letter;
    logic              letter_error;
    logic              last_of_run;
    logic              message_done;
  } out_item_t;

  // One digraph waiting to be ciphered.
  typedef struct packed {
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] second;
    logic              last;
    logic              done;
  } pair_t;

  // Status of the digraph queue seen by both of its neighbours.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Position of a letter in the square.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              found;
  } loc_t;

  // Both letters of a digraph after lookup.
  typedef struct packed {
    loc_t a;
    loc_t b;
    logic last;
    logic done;
  } loc_pair_t;

  // Parallel compare against all cells; scanning backwards lets the first
  // match in row-major order win.
  function automatic loc_t locate(square_t sq, logic [CODE_W-1:0] code);
    loc_t l;
    l.code  = code;
    l.row   = '0;
    l.col   = '0;
    l.found = 1'b0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (sq[r][c] == code) begin
          l.row   = IDX_W'(r);
          l.col   = IDX_W'(c);
          l.found = 1'b1;
        end
      end
    end
    return l;
  endfunction

  // One step right/down when encrypting, left/up when decrypting, with wrap.
  function automatic logic [IDX_W-1:0] wrap_step(logic [IDX_W-1:0] i, logic dec);
    logic [IDX_W-1:0] res;
    if (dec) begin
      res = (i == '0) ? IDX_W'(SIDE - 1) : i - 1'b1;
    end else begin
      res = (i == IDX_W'(SIDE - 1)) ? '0 : i + 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pdc_front.sv
`default_nettype none

module pdc_front
  import pdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_payload,
  input  wire q_status_t q_stat,
  output logic           q_push,
  output pair_t          q_item
);

  logic              holding_r, holding_nxt;
  logic [CODE_W-1:0] held_r, held_nxt;
  logic              pend_r, pend_nxt;
  logic              in_acc;

  // A second digraph still to be queued, or a full queue, blocks new input.
  assign in_stall = pend_r || q_stat.full;
  assign in_acc   = in_valid && !in_stall;

  // Pairing of letters into digraphs, with filler insertion.
  always_comb begin
    holding_nxt = holding_r;
    held_nxt    = held_r;
    pend_nxt    = pend_r;
    q_push      = 1'b0;
    q_item      = '0;
    if (pend_r) begin
      // Odd repeated letter at the end of the message, padded with filler.
      if (!q_stat.full) begin
        q_push   = 1'b1;
        q_item   = '{first: held_r, second: FILLER_X, last: 1'b1, done: 1'b1};
        pend_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!holding_r) begin
        if (in_payload.end_of_message) begin
          q_push = 1'b1;
          q_item = '{first: in_payload.letter, second: FILLER_X, last: 1'b1, done: 1'b1};
        end else begin
          held_nxt    = in_payload.letter;
          holding_nxt = 1'b1;
        end
      end else if (in_payload.letter != held_r) begin
        q_push      = 1'b1;
        q_item      = '{first: held_r, second: in_payload.letter, last: 1'b1,
                        done: in_payload.end_of_message};
        holding_nxt = 1'b0;
      end else begin
        // Repeated letter: close the pair with filler, the letter opens the next.
        q_push = 1'b1;
        if (in_payload.end_of_message) begin
          q_item      = '{first: held_r, second: FILLER_X, last: 1'b0, done: 1'b0};
          pend_nxt    = 1'b1;
          holding_nxt = 1'b0;
        end else begin
          q_item = '{first: held_r, second: FILLER_X, last: 1'b1, done: 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r <= 1'b0;
      held_r    <= '0;
      pend_r    <= 1'b0;
    end else begin
      holding_r <= holding_nxt;
      held_r    <= held_nxt;
      pend_r    <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pdc_queue.sv
`default_nettype none
`include "playfair_digraph_cipher_assert.svh"

module pdc_queue
  import pdc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire pair_t push_item,
  input  wire logic  pop,
  output pair_t      head,
  output q_status_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pair_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign stat.full      = (count_r == CNT_W'(DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign head           = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage of queued digraphs.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `PDC_ASSERT(a_no_overflow, clk, rst_n, push |-> (count_r != CNT_W'(DEPTH)), "queue overflow")
  `PDC_ASSERT(a_no_underflow, clk, rst_n, pop |-> (count_r != '0), "queue underflow")
  `PDC_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1, "fill count did not advance")

endmodule

`default_nettype wire

>>> hdl/pdc_back.sv
`default_nettype none
`include "playfair_digraph_cipher_assert.svh"

module pdc_back
  import pdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire square_t   square,
  input  wire logic      decrypt_mode,
  input  wire pair_t     q_head,
  input  wire q_status_t q_stat,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_payload
);

  // Stage A: located digraph. Stage B: two ciphered results.
  logic      va_r, va_nxt;
  loc_pair_t la_r, la_nxt;
  logic      vb_r, vb_nxt;
  logic      half_r, half_nxt;
  out_item_t res0_r, res0_nxt;
  out_item_t res1_r, res1_nxt;

  logic              out_acc;
  logic              b_free;
  logic              a_adv;
  logic [CODE_W-1:0] oa;
  logic [CODE_W-1:0] ob;

  assign out_acc = vb_r && !out_stall;
  assign b_free  = !vb_r || (out_acc && half_r);
  assign a_adv   = va_r && b_free;
  assign q_pop   = q_stat.not_empty && (!va_r || b_free);

  // Cipher rules on the located pair.
  always_comb begin
    oa = la_r.a.code;
    ob = la_r.b.code;
    if (la_r.a.found && la_r.b.found) begin
      if (la_r.a.row == la_r.b.row) begin
        oa = square[la_r.a.row][wrap_step(la_r.a.col, decrypt_mode)];
        ob = square[la_r.b.row][wrap_step(la_r.b.col, decrypt_mode)];
      end else if (la_r.a.col == la_r.b.col) begin
        oa = square[wrap_step(la_r.a.row, decrypt_mode)][la_r.a.col];
        ob = square[wrap_step(la_r.b.row, decrypt_mode)][la_r.b.col];
      end else begin
        oa = square[la_r.a.row][la_r.b.col];
        ob = square[la_r.b.row][la_r.a.col];
      end
    end
  end

  // Stage advance and result sequencing.
  always_comb begin
    va_nxt   = va_r;
    la_nxt   = la_r;
    vb_nxt   = vb_r;
    half_nxt = half_r;
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    if (q_pop) begin
      va_nxt = 1'b1;
      la_nxt = '{a: locate(square, q_head.first), b: locate(square, q_head.second),
                 last: q_head.last, done: q_head.done};
    end else if (a_adv) begin
      va_nxt = 1'b0;
    end
    if (a_adv) begin
      vb_nxt   = 1'b1;
      half_nxt = 1'b0;
      res0_nxt = '{out_letter: oa, letter_error: !la_r.a.found,
                   last_of_run: 1'b0, message_done: 1'b0};
      res1_nxt = '{out_letter: ob, letter_error: !la_r.b.found,
                   last_of_run: la_r.last, message_done: la_r.done};
    end else if (out_acc) begin
      if (half_r) begin
        vb_nxt = 1'b0;
      end else begin
        half_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      half_r <= 1'b0;
    end else begin
      va_r   <= va_nxt;
      vb_r   <= vb_nxt;
      half_r <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    la_r   <= la_nxt;
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

  assign out_valid   = vb_r;
  assign out_payload = half_r ? res1_r : res0_r;

  `PDC_ASSERT_NEXT(a_second_half, clk, rst_n, out_acc && !half_r, vb_r && half_r, "second result of a pair lost")
  `PDC_ASSERT(a_last_on_second, clk, rst_n, (out_valid && out_payload.last_of_run) |-> half_r, "end of run flagged on first result")
  `PDC_ASSERT_NEXT(a_pop_loads, clk, rst_n, q_pop, va_r, "popped digraph not held in lookup stage")

endmodule

`default_nettype wire

>>> hdl/playfair_digraph_cipher.sv
// Channel  | Ports                               | Direction
// ---------+-------------------------------------+----------
// input    | in_valid, in_stall, in_payload      | letters in
// result   | out_valid, out_stall, out_payload   | cipher letters out
// config   | cfg_we, cfg_index, cfg_wdata        | register writes
//
// A letter is taken every cycle while the digraph queue has room and no padding
// digraph is pending; a letter that closes a digraph yields two results, one per
// cycle unless out_stall is high, so the result port sets sustained throughput.
// A digraph is held in the queue, the lookup stage and the result stage in turn.
// Reset is synchronous and active low; no clearing pass is needed afterwards.
// A stalled result holds its payload; input stalls only when the queue is full
// or a padding digraph is still to be queued.
`default_nettype none

module playfair_digraph_cipher
  import pdc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_payload,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_payload,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ROW_W-1:0]     cfg_wdata
);

  logic      decrypt_mode_r, decrypt_mode_nxt;
  square_t   square_r, square_nxt;
  q_status_t q_stat;
  logic      q_push;
  pair_t     q_item;
  logic      q_pop;
  pair_t     q_head;

  // Configuration register writes.
  always_comb begin
    decrypt_mode_nxt = decrypt_mode_r;
    square_nxt       = square_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECRYPT_MODE: decrypt_mode_nxt = cfg_wdata[0];
        CFG_SQUARE_ROW0:  square_nxt[0]    = cfg_wdata;
        CFG_SQUARE_ROW1:  square_nxt[1]    = cfg_wdata;
        CFG_SQUARE_ROW2:  square_nxt[2]    = cfg_wdata;
        CFG_SQUARE_ROW3:  square_nxt[3]    = cfg_wdata;
        CFG_SQUARE_ROW4:  square_nxt[4]    = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_mode_r <= 1'b0;
      square_r       <= SQUARE_RESET;
    end else begin
      decrypt_mode_r <= decrypt_mode_nxt;
      square_r       <= square_nxt;
    end
  end

  // Front: pairs letters into digraphs.
  pdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  // Queue of digraphs between the two halves.
  pdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // Back: looks up and ciphers each digraph.
  pdc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .square       (square_r),
    .decrypt_mode (decrypt_mode_r),
    .q_head       (q_head),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_payload  (out_payload)
  );

endmodule

`default_nettype wire
